[hw/rtl/pehl_pkg.sv]
package pehl_pkg;

   localparam int NumComp       = 3;
   localparam int EmbDimDefault = 3;

   localparam int CompW    = 16;
   localparam int DiffW    = CompW + 1;
   localparam int GradW    = DiffW + 1;
   localparam int SqW      = 32;
   localparam int EmbW     = 34;
   localparam int AlphaW   = 24;
   localparam int DistW    = 24;
   localparam int SpatialW = AlphaW + DistW;
   localparam int LossW    = 34;
   localparam int SumW     = 48;
   localparam int CountW   = 32;

   // 4.0 in Q.26
   localparam logic [EmbW-1:0]   FourQ26  = EmbW'(1 << 28);
   localparam logic [SumW-1:0]   SumMax   = '1;
   localparam logic [CountW-1:0] CountMax = '1;

   typedef logic signed [CompW-1:0] comp_type;
   typedef logic signed [DiffW-1:0] diff_type;
   typedef logic signed [GradW-1:0] grad_type;
   typedef logic [SqW-1:0]          sq_type;
   typedef logic [EmbW-1:0]         emb_type;
   typedef logic [AlphaW-1:0]       alpha_type;
   typedef logic [DistW-1:0]        dist_type;
   typedef logic [SpatialW-1:0]     spatial_type;
   typedef logic [LossW-1:0]        loss_type;
   typedef logic [SumW-1:0]         sum_type;
   typedef logic [CountW-1:0]       count_type;

   typedef struct packed {
      logic                      first;
      logic                      same;
      dist_type                  dist2;
      comp_type [NumComp-1:0]    u_comp;
      comp_type [NumComp-1:0]    v_comp;
   } pair_stage_type;

   typedef struct packed {
      logic                      first;
      logic                      same;
      diff_type [NumComp-1:0]    diff;
      sq_type [NumComp-1:0]      sq;
      spatial_type               spatial;
   } prod_stage_type;

   typedef struct packed {
      logic                      first;
      loss_type                  loss;
      grad_type [NumComp-1:0]    grad;
   } loss_stage_type;

endpackage

[hw/rtl/pehl_req_if.sv]
interface pehl_req_if import pehl_pkg::*; ();
   logic     valid;
   logic     ready;
   comp_type u_comp0;
   comp_type u_comp1;
   comp_type u_comp2;
   comp_type v_comp0;
   comp_type v_comp1;
   comp_type v_comp2;
   logic     same_label;
   dist_type spatial_dist2;
   logic     first_pair;

   modport source (
      output valid, u_comp0, u_comp1, u_comp2, v_comp0, v_comp1, v_comp2,
             same_label, spatial_dist2, first_pair,
      input  ready
   );
   modport sink (
      input  valid, u_comp0, u_comp1, u_comp2, v_comp0, v_comp1, v_comp2,
             same_label, spatial_dist2, first_pair,
      output ready
   );
endinterface

[hw/rtl/pehl_rsp_if.sv]
interface pehl_rsp_if import pehl_pkg::*; ();
   logic      valid;
   logic      ready;
   loss_type  pair_loss;
   grad_type  grad_u0;
   grad_type  grad_u1;
   grad_type  grad_u2;
   sum_type   loss_total;
   count_type pairs_seen;

   modport source (
      output valid, pair_loss, grad_u0, grad_u1, grad_u2, loss_total, pairs_seen,
      input  ready
   );
   modport sink (
      input  valid, pair_loss, grad_u0, grad_u1, grad_u2, loss_total, pairs_seen,
      output ready
   );
endinterface

[hw/rtl/pehl_csr_if.sv]
interface pehl_csr_if import pehl_pkg::*; ();
   logic      valid;
   logic      ready;
   alpha_type alpha;

   modport source (
      output valid, alpha,
      input  ready
   );
   modport sink (
      input  valid, alpha,
      output ready
   );
endinterface

[hw/rtl/pehl_product.sv]
module pehl_product import pehl_pkg::*; #(
   parameter int EmbDim = EmbDimDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  alpha_type      alpha,
   input  logic           in_valid,
   input  pair_stage_type in_data,
   input  logic           next_load,
   output logic           load,
   output logic           out_valid,
   output prod_stage_type out_data
);

   logic                         valid_ff;
   prod_stage_type               data_ff;
   prod_stage_type               data_in;
   logic signed [2*DiffW-1:0]    prod [NumComp];

   assign load      = !valid_ff || next_load;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.first   = in_data.first;
      data_in.same    = in_data.same;
      data_in.spatial = SpatialW'(in_data.dist2) * SpatialW'(alpha);
      for (int k = 0; k < NumComp; k++) begin
         if (k < EmbDim) begin
            data_in.diff[k] = DiffW'($signed(in_data.u_comp[k]))
                              - DiffW'($signed(in_data.v_comp[k]));
         end else begin
            data_in.diff[k] = '0;
         end
         prod[k]       = $signed(data_in.diff[k]) * $signed(data_in.diff[k]);
         // square of a 17-bit difference stays below 2^32
         data_in.sq[k] = prod[k][SqW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/pehl_hinge.sv]
module pehl_hinge import pehl_pkg::*; #(
   parameter int EmbDim = EmbDimDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  prod_stage_type in_data,
   input  logic           next_load,
   output logic           load,
   output logic           out_valid,
   output loss_stage_type out_data
);

   logic                  valid_ff;
   loss_stage_type        data_ff;
   loss_stage_type        data_in;
   emb_type               emb;
   logic [SpatialW:0]     far_sum;
   grad_type              grad2;

   assign load      = !valid_ff || next_load;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      emb = '0;
      for (int k = 0; k < NumComp; k++) begin
         emb = emb + EmbW'(in_data.sq[k]);
      end
      far_sum = (SpatialW+1)'(emb) + (SpatialW+1)'(in_data.spatial);

      data_in.first = in_data.first;
      data_in.loss  = '0;
      if (in_data.same) begin
         if (SpatialW'(emb) > in_data.spatial) begin
            data_in.loss = LossW'(SpatialW'(emb) - in_data.spatial);
         end
      end else begin
         if (far_sum < (SpatialW+1)'(FourQ26)) begin
            data_in.loss = LossW'((SpatialW+1)'(FourQ26) - far_sum);
         end
      end

      for (int k = 0; k < NumComp; k++) begin
         grad2 = {in_data.diff[k], 1'b0};
         if (data_in.loss == '0 || k >= EmbDim) begin
            data_in.grad[k] = '0;
         end else if (in_data.same) begin
            data_in.grad[k] = grad2;
         end else begin
            data_in.grad[k] = -grad2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/pehl_accum.sv]
module pehl_accum import pehl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  loss_stage_type in_data,
   output logic           load,
   pehl_rsp_if.source     rsp_port
);

   logic          valid_ff;
   sum_type       loss_sum_ff;
   sum_type       loss_sum_in;
   count_type     pair_count_ff;
   count_type     pair_count_in;
   loss_type      loss_ff;
   grad_type      grad_ff [NumComp];
   sum_type       base_sum;
   count_type     base_count;
   logic [SumW:0] sum_wide;
   logic          take;

   assign load = !valid_ff || rsp_port.ready;
   assign take = load && in_valid;

   always_comb begin
      base_sum   = in_data.first ? '0 : loss_sum_ff;
      base_count = in_data.first ? '0 : pair_count_ff;
      sum_wide   = (SumW+1)'(base_sum) + (SumW+1)'(in_data.loss);
      loss_sum_in   = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
      pair_count_in = (base_count == CountMax) ? CountMax : base_count + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         loss_sum_ff   <= '0;
         pair_count_ff <= '0;
      end else begin
         if (load) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            loss_sum_ff   <= loss_sum_in;
            pair_count_ff <= pair_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         loss_ff <= in_data.loss;
         for (int k = 0; k < NumComp; k++) begin
            grad_ff[k] <= in_data.grad[k];
         end
      end
   end

   // the running totals double as the result's total fields
   assign rsp_port.valid      = valid_ff;
   assign rsp_port.pair_loss  = loss_ff;
   assign rsp_port.grad_u0    = grad_ff[0];
   assign rsp_port.grad_u1    = grad_ff[1];
   assign rsp_port.grad_u2    = grad_ff[2];
   assign rsp_port.loss_total = loss_sum_ff;
   assign rsp_port.pairs_seen = pair_count_ff;

`ifndef SYNTHESIS
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> pair_count_ff != '0)
      else $error("result shown with zero pair count");

   a_total_covers_loss: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> loss_sum_ff >= SumW'(loss_ff))
      else $error("running loss below this pair's loss");

   a_zero_loss_zero_grad: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && loss_ff == '0) |->
         (grad_ff[0] == '0 && grad_ff[1] == '0 && grad_ff[2] == '0))
      else $error("gradient on a pair with zero loss");

   a_stall_holds_totals: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_port.ready) |=> ($stable(loss_sum_ff) && $stable(pair_count_ff)))
      else $error("totals moved while the result was stalled");
`endif

endmodule

[hw/rtl/pair_embedding_hinge_loss_unit.sv]
// channel   direction  payload
// req_port  in         u_comp0..2, v_comp0..2, same_label, spatial_dist2, first_pair
// rsp_port  out        pair_loss, grad_u0..2, loss_total, pairs_seen
// csr_port  in         alpha (always ready)
//
// one transaction per cycle sustained while rsp is ready; four register stages
// from req to rsp (input, products, hinge, result/accumulator)
// reset clears stage valids, alpha, loss sum and pair count
// a stalled rsp backs up stage by stage; each stage still takes data while
// the one after it can move
module pair_embedding_hinge_loss_unit import pehl_pkg::*; #(
   parameter int EmbDim = EmbDimDefault
) (
   input  logic       clock,
   input  logic       reset,
   pehl_req_if.sink   req_port,
   pehl_rsp_if.source rsp_port,
   pehl_csr_if.sink   csr_port
);

   alpha_type      alpha_ff;
   logic           in_valid_ff;
   pair_stage_type in_ff;
   pair_stage_type in_in;
   logic           in_load;
   logic           prod_load;
   logic           prod_valid;
   prod_stage_type prod_data;
   logic           hinge_load;
   logic           hinge_valid;
   loss_stage_type hinge_data;
   logic           acc_load;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
      end else if (csr_port.valid) begin
         alpha_ff <= csr_port.alpha;
      end
   end

   assign in_load        = !in_valid_ff || prod_load;
   assign req_port.ready = in_load;

   always_comb begin
      in_in.first     = req_port.first_pair;
      in_in.same      = req_port.same_label;
      in_in.dist2     = req_port.spatial_dist2;
      in_in.u_comp[0] = req_port.u_comp0;
      in_in.u_comp[1] = req_port.u_comp1;
      in_in.u_comp[2] = req_port.u_comp2;
      in_in.v_comp[0] = req_port.v_comp0;
      in_in.v_comp[1] = req_port.v_comp1;
      in_in.v_comp[2] = req_port.v_comp2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_port.valid) begin
         in_ff <= in_in;
      end
   end

   pehl_product #(.EmbDim(EmbDim)) u_product (
      .clock     (clock),
      .reset     (reset),
      .alpha     (alpha_ff),
      .in_valid  (in_valid_ff),
      .in_data   (in_ff),
      .next_load (hinge_load),
      .load      (prod_load),
      .out_valid (prod_valid),
      .out_data  (prod_data)
   );

   pehl_hinge #(.EmbDim(EmbDim)) u_hinge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_data   (prod_data),
      .next_load (acc_load),
      .load      (hinge_load),
      .out_valid (hinge_valid),
      .out_data  (hinge_data)
   );

   pehl_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (hinge_valid),
      .in_data  (hinge_data),
      .load     (acc_load),
      .rsp_port (rsp_port)
   );

endmodule

[sim/pehl_loss_check.sv]
module pehl_loss_check import pehl_pkg::*; #(
   parameter int EmbDim = EmbDimDefault
) (
   input  logic clock,
   input  logic reset,
   pehl_req_if  req_mon,
   pehl_rsp_if  rsp_mon,
   pehl_csr_if  csr_mon,
   output int   mismatches,
   output int   outstanding
);

   localparam int MarginW    = SpatialW + 2;
   localparam int MaxPrinted = 20;

   typedef struct packed {
      loss_type               pair_loss;
      grad_type [NumComp-1:0] grad;
      sum_type                total;
      count_type              count;
   } hinge_result_type;

   alpha_type              alpha_q;
   sum_type                acc_sum;
   count_type              acc_count;
   hinge_result_type       expected_losses[$];
   hinge_result_type       want;
   hinge_result_type       predicted;
   comp_type [NumComp-1:0] req_u;
   comp_type [NumComp-1:0] req_v;
   int                     results_checked;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) begin
         $display("mismatch: %s", msg);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] wanted);
      if (got !== wanted) begin
         report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                   results_checked, name, got, wanted));
      end
   endtask

   // hinge loss of one pair; also advances the running sum and count
   function automatic hinge_result_type predict_hinge(input comp_type [NumComp-1:0] u,
                                                      input comp_type [NumComp-1:0] v,
                                                      input logic same,
                                                      input dist_type d2,
                                                      input logic first);
      hinge_result_type       r;
      diff_type               d;
      logic signed [EmbW-1:0] dw;
      emb_type                emb;
      spatial_type            spatial;
      logic signed [MarginW-1:0] margin;
      logic [SumW:0]          wide_sum;
      grad_type [NumComp-1:0] g;
      emb = '0;
      g   = '0;
      for (int k = 0; k < NumComp; k++) begin
         if (k < EmbDim) begin
            d    = diff_type'($signed(u[k])) - diff_type'($signed(v[k]));
            dw   = d;
            emb  = emb + emb_type'(dw * dw);
            g[k] = {d, 1'b0};
         end
      end
      spatial = spatial_type'(alpha_q) * spatial_type'(d2);
      if (same) begin
         margin = MarginW'(emb) - MarginW'(spatial);
      end else begin
         margin = MarginW'(FourQ26) - MarginW'(emb) - MarginW'(spatial);
      end
      if (margin <= 0) begin
         r.pair_loss = '0;
         g = '0;
      end else begin
         r.pair_loss = loss_type'(margin);
      end
      if (!same) begin
         for (int k = 0; k < NumComp; k++) g[k] = -g[k];
      end
      r.grad = g;
      if (first) begin
         acc_sum   = '0;
         acc_count = '0;
      end
      wide_sum = acc_sum + r.pair_loss;
      acc_sum  = wide_sum[SumW] ? SumMax : wide_sum[SumW-1:0];
      if (acc_count != CountMax) acc_count = acc_count + 1'b1;
      r.total = acc_sum;
      r.count = acc_count;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         alpha_q         = '0;
         acc_sum         = '0;
         acc_count       = '0;
         mismatches      = 0;
         results_checked = 0;
         expected_losses.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) alpha_q = csr_mon.alpha;
         if (req_mon.valid && req_mon.ready) begin
            req_u = {req_mon.u_comp2, req_mon.u_comp1, req_mon.u_comp0};
            req_v = {req_mon.v_comp2, req_mon.v_comp1, req_mon.v_comp0};
            predicted = predict_hinge(req_u, req_v, req_mon.same_label,
                                      req_mon.spatial_dist2, req_mon.first_pair);
            expected_losses = {expected_losses, predicted};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_losses.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing pending",
                                         results_checked));
            end else begin
               want = expected_losses.pop_front();
               check_field("pair_loss", 64'(rsp_mon.pair_loss), 64'(want.pair_loss));
               check_field("grad_u0", 64'(rsp_mon.grad_u0), 64'(want.grad[0]));
               check_field("grad_u1", 64'(rsp_mon.grad_u1), 64'(want.grad[1]));
               check_field("grad_u2", 64'(rsp_mon.grad_u2), 64'(want.grad[2]));
               check_field("loss_total", 64'(rsp_mon.loss_total), 64'(want.total));
               check_field("pairs_seen", 64'(rsp_mon.pairs_seen), 64'(want.count));
            end
            results_checked++;
         end
      end
      outstanding = expected_losses.size();
   end

endmodule

[sim/pair_embedding_hinge_loss_unit_tb.sv]
module pair_embedding_hinge_loss_unit_tb;
   import pehl_pkg::*;

   localparam int CycleLimit   = 500000;
   localparam int MaxLossPairs = 40;
   localparam int PhaseItems   = 330;
   localparam comp_type CompMax = 16'sh7fff;
   localparam comp_type CompMin = 16'sh8000;

   typedef struct packed {
      logic                   first;
      logic                   same;
      dist_type               d2;
      comp_type [NumComp-1:0] u;
      comp_type [NumComp-1:0] v;
   } pair_item_type;

   logic          clock;
   logic          reset;
   int            req_idle_pct = 17;
   int            rsp_idle_pct = 45;
   int            cycle_count  = 0;
   int            mismatches;
   int            outstanding;
   pair_item_type item;

   pehl_req_if req_port ();
   pehl_rsp_if rsp_port ();
   pehl_csr_if csr_port ();

   pair_embedding_hinge_loss_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .csr_port (csr_port)
   );

   pehl_loss_check loss_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_port),
      .rsp_mon     (rsp_port),
      .csr_mon     (csr_port),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      rsp_port.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_port.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic pair_item_type make_pair(input int u0, input int u1, input int u2,
                                               input int v0, input int v1, input int v2,
                                               input logic same, input int d2,
                                               input logic first);
      pair_item_type p;
      p.u     = {comp_type'(u2), comp_type'(u1), comp_type'(u0)};
      p.v     = {comp_type'(v2), comp_type'(v1), comp_type'(v0)};
      p.same  = same;
      p.d2    = dist_type'(d2);
      p.first = first;
      return p;
   endfunction

   // half the pairs sit close together so different-label losses stay alive
   function automatic pair_item_type random_pair();
      pair_item_type p;
      int            span;
      int            delta;
      logic          near;
      span = $urandom_range(12);
      near = 1'($urandom_range(1));
      for (int k = 0; k < NumComp; k++) begin
         p.u[k] = comp_type'($urandom);
         delta  = int'($urandom_range(2 << span)) - (1 << span);
         p.v[k] = near ? p.u[k] + comp_type'(delta) : comp_type'($urandom);
      end
      case ($urandom_range(9))
         0:               p.d2 = '0;
         1, 2, 3, 4, 5:   p.d2 = dist_type'($urandom_range(1 << $urandom_range(14)));
         default:         p.d2 = dist_type'($urandom);
      endcase
      p.same  = 1'($urandom_range(1));
      p.first = ($urandom_range(39) == 0);
      return p;
   endfunction

   task automatic send_pair(input pair_item_type p);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_port.valid <= 1'b0;
         @(negedge clock);
      end
      req_port.valid         <= 1'b1;
      req_port.u_comp0       <= p.u[0];
      req_port.u_comp1       <= p.u[1];
      req_port.u_comp2       <= p.u[2];
      req_port.v_comp0       <= p.v[0];
      req_port.v_comp1       <= p.v[1];
      req_port.v_comp2       <= p.v[2];
      req_port.same_label    <= p.same;
      req_port.spatial_dist2 <= p.d2;
      req_port.first_pair    <= p.first;
      do @(posedge clock); while (req_port.ready !== 1'b1);
   endtask

   // stop sending and let every pending result come out of the pipeline
   task automatic settle_pipe();
      @(negedge clock);
      req_port.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_alpha(input alpha_type value);
      @(negedge clock);
      csr_port.valid <= 1'b1;
      csr_port.alpha <= value;
      do @(posedge clock); while (csr_port.ready !== 1'b1);
      @(negedge clock);
      csr_port.valid <= 1'b0;
   endtask

   initial begin
      reset                  = 1'b1;
      req_port.valid         = 1'b0;
      req_port.u_comp0       = '0;
      req_port.u_comp1       = '0;
      req_port.u_comp2       = '0;
      req_port.v_comp0       = '0;
      req_port.v_comp1       = '0;
      req_port.v_comp2       = '0;
      req_port.same_label    = 1'b0;
      req_port.spatial_dist2 = '0;
      req_port.first_pair    = 1'b0;
      csr_port.valid         = 1'b0;
      csr_port.alpha         = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pairs with alpha at 1.0
      write_alpha(24'h010000);
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0));
      send_pair(make_pair(CompMax, CompMax, CompMax, CompMin, CompMin, CompMin,
                          1'b1, 0, 1'b0));
      send_pair(make_pair(CompMax, CompMax, CompMax, CompMin, CompMin, CompMin,
                          1'b0, 0, 1'b0));
      send_pair(make_pair(CompMin, CompMin, CompMin, CompMax, CompMax, CompMax,
                          1'b1, 24'hffffff, 1'b0));
      send_pair(make_pair(CompMin, CompMin, CompMin, CompMax, CompMax, CompMax,
                          1'b1, 1, 1'b0));
      send_pair(make_pair(100, -200, 300, 0, 0, 0, 1'b0, 16, 1'b0));
      send_pair(make_pair(CompMin, CompMin, CompMin, CompMin, CompMin, CompMin,
                          1'b0, 4095, 1'b0));
      // spatial term lands exactly on 4.0
      send_pair(make_pair(CompMin, CompMin, CompMin, CompMin, CompMin, CompMin,
                          1'b0, 4096, 1'b0));
      // same label, embedding distance equal to spatial term
      send_pair(make_pair(256, 0, 0, 0, 0, 0, 1'b1, 1, 1'b0));
      send_pair(make_pair(257, 0, 0, 0, 0, 0, 1'b1, 1, 1'b0));
      send_pair(make_pair(-5, 7, CompMax, 3, -9, CompMin, 1'b1, 24'h800000, 1'b1));
      send_pair(make_pair(CompMax, 0, CompMin, CompMin, 0, CompMax, 1'b0, 0, 1'b0));
      settle_pipe();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       write_alpha('0);
            1:       write_alpha(24'hffffff);
            2:       write_alpha(24'h010000);
            3:       write_alpha(alpha_type'($urandom));
            4:       write_alpha(alpha_type'($urandom_range(24'h03ffff)));
            default: write_alpha(24'h000001);
         endcase
         if (phase < 2) begin
            req_idle_pct = 17;
            rsp_idle_pct = 45;
         end else if (phase < 4) begin
            req_idle_pct = 45;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (int i = 0; i < PhaseItems; i++) begin
            if (phase == 3 && i == PhaseItems / 2) settle_pipe();
            send_pair(random_pair());
         end
         settle_pipe();
      end

      // a run of max-loss pairs piling up the loss sum
      write_alpha('0);
      for (int i = 0; i < MaxLossPairs; i++) begin
         item = make_pair(CompMax, CompMax, CompMax, CompMin, CompMin, CompMin,
                          1'b1, $urandom_range(24'hffffff), (i == 0));
         send_pair(item);
      end
      item       = random_pair();
      item.first = 1'b1;
      send_pair(item);
      settle_pipe();

      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/pehl_pkg.sv
hw/rtl/pehl_req_if.sv
hw/rtl/pehl_rsp_if.sv
hw/rtl/pehl_csr_if.sv
hw/rtl/pehl_product.sv
hw/rtl/pehl_hinge.sv
hw/rtl/pehl_accum.sv
hw/rtl/pair_embedding_hinge_loss_unit.sv
sim/pehl_loss_check.sv
sim/pair_embedding_hinge_loss_unit_tb.sv
